[rtl/cpa_pkg.sv]
// cpa_pkg: widths, constants and payload types of the chirp packet airtime block
// used by the channel interfaces, the divider cells and the top level; no dependencies
`timescale 1ns / 1ps

package cpa_pkg;

    // input and output field widths
    localparam int SF_W    = 4;
    localparam int BW_W    = 20;
    localparam int CR_W    = 4;
    localparam int PRE_W   = 16;
    localparam int PL_W    = 8;
    localparam int AIR_W   = 48;

    // validity limits
    localparam logic [SF_W-1:0] SF_MIN = 4'd6;
    localparam logic [CR_W-1:0] CR_MIN = 4'd5;

    // low data rate test: (1000 << sf) > (bw << 4)
    localparam int CHIP_CMP_W = 25;
    localparam logic [CHIP_CMP_W-1:0] CHIP_SCALE = 25'd1000;
    localparam int BW_SHIFT   = 4;

    // payload symbol ceiling division: (num + den - 1) / den
    localparam int NUM_W   = 12;
    localparam int DEN_W   = 6;
    localparam int Q_W     = 8;
    localparam int QCR_W   = Q_W + CR_W;
    localparam logic [NUM_W-1:0] HDR_BIAS = 12'd44;

    // four times the symbol count: 4*pre + 17 + 32 + 4*q*cr
    localparam int SYM4_W  = 19;
    localparam logic [SYM4_W-1:0] SYM_BASE = 19'd49;

    // 10^6 / 4 = 15625 * 2^4, so airtime = (sym4 * 15625 << (sf + 4)) / bw
    localparam int SCALE_W = 14;
    localparam logic [SCALE_W-1:0] SCALE = 14'd15625;
    localparam int MUL_W   = SYM4_W + SCALE_W;
    localparam int M_W     = 32;
    localparam int SHIFT_W = 5;
    localparam logic [SHIFT_W-1:0] SHIFT_BIAS = 5'd4;
    localparam int DIV_W   = 51;

    typedef struct packed {
        logic [SF_W-1:0]  spreading_factor;
        logic [BW_W-1:0]  bandwidth_hz;
        logic [CR_W-1:0]  coding_rate;
        logic [PRE_W-1:0] preamble_symbols;
        logic [PL_W-1:0]  payload_bytes;
    } t_pkt;

    typedef struct packed {
        logic [AIR_W-1:0] airtime_us;
        logic             invalid;
        logic             low_rate_opt;
    } t_res;

    typedef struct packed {
        logic invalid;
        logic ldro;
    } t_flags;

    // carried alongside the ceiling division
    typedef struct packed {
        t_flags           flags;
        logic [PRE_W-1:0] pre;
        logic [CR_W-1:0]  cr;
        logic [SF_W-1:0]  sf;
        logic [BW_W-1:0]  bw;
    } t_side_a;

    // pipeline control handed to a chain of cells
    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage

[rtl/cpa_stream_if.sv]
// cpa_stream_if: valid/ready channels for packet descriptions and airtime results
// depends on cpa_pkg for the payload types
`timescale 1ns / 1ps

interface cpa_pkt_if;
    logic              valid;
    logic              ready;
    cpa_pkg::t_pkt     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpa_res_if;
    logic              valid;
    logic              ready;
    cpa_pkg::t_res     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/chirp_packet_airtime.sv]
// chirp_packet_airtime: time on air of a chirp packet, explicit header with crc
// depends on cpa_pkg, cpa_stream_if and cpa_div_chain
`timescale 1ns / 1ps

// usage
//   i_pkt: packet descriptions in (sf, bandwidth in hz, coding rate, preamble, bytes)
//   o_res: airtime in microseconds, invalid flag and low data rate flag
//   a transaction moves on either channel when valid and ready are both high
// throughput: one transaction per cycle, sustained while o_res.ready stays high
// pipeline: an input transaction passes through arithmetic stage 1, a row of 12
//   division cells for the payload symbol ceiling, arithmetic stages 2 to 4, a row
//   of 51 division cells for the final division by bandwidth (one quotient bit per
//   cell) and the output register before its result transaction
// reset: synchronous, active low; clears every stage valid and the output and
//   skid valid flags, so nothing is presented after reset
// stalls: the output register is backed by a one-entry skid register; when
//   the receiver holds ready low the next finished result parks in the skid
//   and i_pkt.ready falls, freezing the whole pipeline until the skid drains
// airtime saturates at 2^48 - 1; a rejected description returns zero airtime
module chirp_packet_airtime (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cpa_pkt_if.sink          i_pkt,
    cpa_res_if.source        o_res
);

    // pipeline advance, dropped only while the skid holds a result
    logic en;

    // ---------------------------------------------------------------
    // stage 1: validity, low data rate test, ceiling division operands
    // ---------------------------------------------------------------
    logic                                 n_inv, n_ldro;
    logic [cpa_pkg::CHIP_CMP_W-1:0]       chips_k, bw_k;
    logic [cpa_pkg::SF_W-1:0]             sf_adj;
    logic [cpa_pkg::DEN_W-1:0]            n_den;
    logic [cpa_pkg::NUM_W-1:0]            num_a, num_b, n_np;
    cpa_pkg::t_side_a                     n_side_a;

    logic                                 r_s1_valid;
    logic [cpa_pkg::NUM_W-1:0]            r_s1_np;
    logic [cpa_pkg::DEN_W-1:0]            r_s1_den;
    cpa_pkg::t_side_a                     r_s1_side;

    always_comb begin
        n_inv   = (i_pkt.data.spreading_factor < cpa_pkg::SF_MIN)
               || (i_pkt.data.coding_rate < cpa_pkg::CR_MIN)
               || (i_pkt.data.bandwidth_hz == '0);
        chips_k = cpa_pkg::CHIP_SCALE << i_pkt.data.spreading_factor;
        bw_k    = cpa_pkg::CHIP_CMP_W'(i_pkt.data.bandwidth_hz) << cpa_pkg::BW_SHIFT;
        n_ldro  = (chips_k > bw_k);
        // den = 4 * (sf - 2 * ldro); garbage for rejected descriptions, masked later
        sf_adj  = i_pkt.data.spreading_factor - {2'b00, n_ldro, 1'b0};
        n_den   = {sf_adj, 2'b00};
        // num = 8 * bytes + 44 - 4 * sf, only its positive part matters
        num_a   = cpa_pkg::NUM_W'({i_pkt.data.payload_bytes, 3'b000}) + cpa_pkg::HDR_BIAS;
        num_b   = cpa_pkg::NUM_W'({i_pkt.data.spreading_factor, 2'b00});
        n_np    = (num_a > num_b)
                ? (num_a - num_b + cpa_pkg::NUM_W'(n_den) - cpa_pkg::NUM_W'(1))
                : '0;
        n_side_a.flags.invalid = n_inv;
        n_side_a.flags.ldro    = n_ldro;
        n_side_a.pre           = i_pkt.data.preamble_symbols;
        n_side_a.cr            = i_pkt.data.coding_rate;
        n_side_a.sf            = i_pkt.data.spreading_factor;
        n_side_a.bw            = i_pkt.data.bandwidth_hz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_pkt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_np   <= n_np;
            r_s1_den  <= n_den;
            r_s1_side <= n_side_a;
        end
    end

    // ---------------------------------------------------------------
    // ceiling division row: q = (num + den - 1) / den
    // ---------------------------------------------------------------
    cpa_pkg::t_pipe_ctl                   a_ctl;
    logic                                 a_valid;
    logic [cpa_pkg::NUM_W-1:0]            a_word;
    logic [$bits(cpa_pkg::t_side_a)-1:0]  a_side_bits;
    cpa_pkg::t_side_a                     a_side;

    assign a_ctl  = '{en: en, valid: r_s1_valid};
    assign a_side = cpa_pkg::t_side_a'(a_side_bits);

    cpa_div_chain #(
        .DEN_W  (cpa_pkg::DEN_W),
        .WORD_W (cpa_pkg::NUM_W),
        .SIDE_W ($bits(cpa_pkg::t_side_a))
    ) u_ceil_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (a_ctl),
        .i_word  (r_s1_np),
        .i_den   (r_s1_den),
        .i_side  (r_s1_side),
        .o_valid (a_valid),
        .o_word  (a_word),
        .o_side  (a_side_bits)
    );

    // ---------------------------------------------------------------
    // stage 2: sym4 = 4 * preamble + 49 + 4 * q * cr
    // ---------------------------------------------------------------
    logic [cpa_pkg::QCR_W-1:0]            qcr;
    logic [cpa_pkg::SYM4_W-1:0]           n_sym4;

    logic                                 r_s2_valid;
    logic [cpa_pkg::SYM4_W-1:0]           r_s2_sym4;
    logic [cpa_pkg::SF_W-1:0]             r_s2_sf;
    logic [cpa_pkg::BW_W-1:0]             r_s2_bw;
    cpa_pkg::t_flags                      r_s2_flags;

    always_comb begin
        // for accepted descriptions the quotient never exceeds 129, so its low byte is exact
        qcr    = cpa_pkg::QCR_W'(a_word[cpa_pkg::Q_W-1:0]) * cpa_pkg::QCR_W'(a_side.cr);
        n_sym4 = cpa_pkg::SYM4_W'({a_side.pre, 2'b00}) + cpa_pkg::SYM_BASE
               + cpa_pkg::SYM4_W'({qcr, 2'b00});
    end

    // ---------------------------------------------------------------
    // stage 3: m = sym4 * 15625
    // stage 4: dividend = m << (sf + 4)
    // ---------------------------------------------------------------
    logic [cpa_pkg::MUL_W-1:0]            mul_full;
    logic [cpa_pkg::SHIFT_W-1:0]          shamt;

    logic                                 r_s3_valid;
    logic [cpa_pkg::M_W-1:0]              r_s3_m;
    logic [cpa_pkg::SF_W-1:0]             r_s3_sf;
    logic [cpa_pkg::BW_W-1:0]             r_s3_bw;
    cpa_pkg::t_flags                      r_s3_flags;

    logic                                 r_s4_valid;
    logic [cpa_pkg::DIV_W-1:0]            r_s4_d;
    logic [cpa_pkg::BW_W-1:0]             r_s4_bw;
    cpa_pkg::t_flags                      r_s4_flags;

    assign mul_full = cpa_pkg::MUL_W'(r_s2_sym4) * cpa_pkg::MUL_W'(cpa_pkg::SCALE);
    assign shamt    = cpa_pkg::SHIFT_W'(r_s3_sf) + cpa_pkg::SHIFT_BIAS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= a_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_sym4  <= n_sym4;
            r_s2_sf    <= a_side.sf;
            r_s2_bw    <= a_side.bw;
            r_s2_flags <= a_side.flags;

            // for accepted descriptions the product stays below 2^32
            r_s3_m     <= mul_full[cpa_pkg::M_W-1:0];
            r_s3_sf    <= r_s2_sf;
            r_s3_bw    <= r_s2_bw;
            r_s3_flags <= r_s2_flags;

            r_s4_d     <= cpa_pkg::DIV_W'(r_s3_m) << shamt;
            r_s4_bw    <= r_s3_bw;
            r_s4_flags <= r_s3_flags;
        end
    end

    // ---------------------------------------------------------------
    // airtime division row: dividend / bandwidth, 51 quotient bits
    // ---------------------------------------------------------------
    cpa_pkg::t_pipe_ctl                   b_ctl;
    logic                                 b_valid;
    logic [cpa_pkg::DIV_W-1:0]            b_word;
    logic [$bits(cpa_pkg::t_flags)-1:0]   b_side_bits;
    cpa_pkg::t_flags                      b_flags;

    assign b_ctl   = '{en: en, valid: r_s4_valid};
    assign b_flags = cpa_pkg::t_flags'(b_side_bits);

    cpa_div_chain #(
        .DEN_W  (cpa_pkg::BW_W),
        .WORD_W (cpa_pkg::DIV_W),
        .SIDE_W ($bits(cpa_pkg::t_flags))
    ) u_air_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (b_ctl),
        .i_word  (r_s4_d),
        .i_den   (r_s4_bw),
        .i_side  (r_s4_flags),
        .o_valid (b_valid),
        .o_word  (b_word),
        .o_side  (b_side_bits)
    );

    // ---------------------------------------------------------------
    // finishing: saturation and rejected description masking
    // ---------------------------------------------------------------
    cpa_pkg::t_res                        n_res;
    logic                                 sat;
    logic                                 fin_valid;

    always_comb begin
        sat = |b_word[cpa_pkg::DIV_W-1:cpa_pkg::AIR_W];
        if (b_flags.invalid) begin
            n_res.airtime_us = '0;
        end else if (sat) begin
            n_res.airtime_us = '1;
        end else begin
            n_res.airtime_us = b_word[cpa_pkg::AIR_W-1:0];
        end
        n_res.invalid      = b_flags.invalid;
        n_res.low_rate_opt = b_flags.ldro & ~b_flags.invalid;
    end

    // a finished result leaves the pipeline only while it advances
    assign fin_valid = b_valid & en;

    // ---------------------------------------------------------------
    // output register with one-entry skid
    // ---------------------------------------------------------------
    logic                                 r_out_valid;
    cpa_pkg::t_res                        r_out;
    logic                                 r_skid_valid;
    cpa_pkg::t_res                        r_skid;

    assign en = ~r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (o_res.ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= fin_valid;
            end
        end else if (fin_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res.ready || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (fin_valid) begin
            r_skid <= n_res;
        end
    end

    assign i_pkt.ready = en;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

`ifndef SYNTHESIS
    // the skid only ever holds a result behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full with output register empty");

    // the skid fills only when the output was stalled
    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !o_res.ready))
        else $error("skid register filled without a stalled output");

    // a draining skid moves its result into the output register
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_skid_valid) && $past(i_rst_n)) |-> r_out_valid)
        else $error("skid result lost on drain");

    // rejected descriptions report neither airtime nor low data rate
    a_invalid_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.invalid)
            |-> (o_res.data.airtime_us == '0 && !o_res.data.low_rate_opt))
        else $error("rejected description carries a result");
`endif

endmodule

[rtl/cpa_div_cell.sv]
// cpa_div_cell: one restoring division cell, one quotient bit per cycle while i_ctl.en is high
// depends on cpa_pkg for the pipeline control struct
`timescale 1ns / 1ps

module cpa_div_cell #(
    parameter int DEN_W  = 6,
    parameter int WORD_W = 12,
    parameter int SIDE_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cpa_pkg::t_pipe_ctl i_ctl,
    input  logic [DEN_W-1:0]   i_rem,
    input  logic [WORD_W-1:0]  i_word,
    input  logic [DEN_W-1:0]   i_den,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    output logic [DEN_W-1:0]   o_rem,
    output logic [WORD_W-1:0]  o_word,
    output logic [DEN_W-1:0]   o_den,
    output logic [SIDE_W-1:0]  o_side
);

    logic              r_valid;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [WORD_W-1:0] r_word, n_word;
    logic [DEN_W-1:0]  r_den;
    logic [SIDE_W-1:0] r_side;
    logic [DEN_W:0]    trial, diff;
    logic              ge;

    // dividend bits leave the top of the word, quotient bits enter at the bottom
    always_comb begin
        trial  = {i_rem, i_word[WORD_W-1]};
        diff   = trial - {1'b0, i_den};
        ge     = (trial >= {1'b0, i_den});
        n_rem  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        n_word = {i_word[WORD_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rem  <= n_rem;
            r_word <= n_word;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_word  = r_word;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

[rtl/cpa_div_chain.sv]
// cpa_div_chain: row of division cells, one cell per dividend bit
// depends on cpa_pkg and cpa_div_cell
`timescale 1ns / 1ps

module cpa_div_chain #(
    parameter int DEN_W  = 6,
    parameter int WORD_W = 12,
    parameter int SIDE_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cpa_pkg::t_pipe_ctl i_ctl,
    input  logic [WORD_W-1:0]  i_word,
    input  logic [DEN_W-1:0]   i_den,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    output logic [WORD_W-1:0]  o_word,
    output logic [SIDE_W-1:0]  o_side
);

    logic [WORD_W:0]    valid_tap;
    logic [DEN_W-1:0]   rem_tap  [WORD_W+1];
    logic [WORD_W-1:0]  word_tap [WORD_W+1];
    logic [DEN_W-1:0]   den_tap  [WORD_W+1];
    logic [SIDE_W-1:0]  side_tap [WORD_W+1];
    cpa_pkg::t_pipe_ctl cell_ctl [WORD_W];

    assign valid_tap[0] = i_ctl.valid;
    assign rem_tap[0]   = '0;
    assign word_tap[0]  = i_word;
    assign den_tap[0]   = i_den;
    assign side_tap[0]  = i_side;

    for (genvar g = 0; g < WORD_W; g++) begin : g_cell
        assign cell_ctl[g] = '{en: i_ctl.en, valid: valid_tap[g]};

        cpa_div_cell #(
            .DEN_W  (DEN_W),
            .WORD_W (WORD_W),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl[g]),
            .i_rem   (rem_tap[g]),
            .i_word  (word_tap[g]),
            .i_den   (den_tap[g]),
            .i_side  (side_tap[g]),
            .o_valid (valid_tap[g+1]),
            .o_rem   (rem_tap[g+1]),
            .o_word  (word_tap[g+1]),
            .o_den   (den_tap[g+1]),
            .o_side  (side_tap[g+1])
        );
    end

    // after the last cell the word holds the whole quotient
    assign o_valid = valid_tap[WORD_W];
    assign o_word  = word_tap[WORD_W];
    assign o_side  = side_tap[WORD_W];

endmodule
